>>> design/ptg_pkg.sv
package ptg_pkg;

  localparam int unsigned GateCount   = 12;
  localparam int unsigned GroupGates  = 6;
  localparam int unsigned SchedCount  = 8;
  localparam int unsigned RatioUsed   = 4;
  localparam int unsigned SumGate     = 5;
  localparam int unsigned QuotWidth   = 24;

  localparam logic [2:0] RegXA    = 3'd0;
  localparam logic [2:0] RegYA    = 3'd1;
  localparam logic [2:0] RegXB    = 3'd2;
  localparam logic [2:0] RegYB    = 3'd3;
  localparam logic [2:0] RegPulse = 3'd4;

  localparam logic [31:0] ResetXA    = 32'h0705_0403;
  localparam logic [31:0] ResetYA    = 32'h0403_0202;
  localparam logic [31:0] ResetXB    = 32'h0B07_0605;
  localparam logic [31:0] ResetYB    = 32'h0404_0302;
  localparam logic [15:0] ResetPulse = 16'd10;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic       load;      // capture the request, clear or expire gates, fire base gates on an edge
    logic       div_start; // start a division for slot
    logic       div_step;  // one restoring division step
    logic       sched;     // apply schedule update for slot
    logic       sums;      // fire sum gates and register the gate outputs
    logic [2:0] slot;
  } ptg_cmd_t;

  typedef struct packed {
    logic restart;
    logic skip;     // X of slot is zero
  } ptg_stat_t;

endpackage

>>> design/ptg_ctrl.sv
module ptg_ctrl
  import ptg_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  input  ptg_stat_t stat_i,
  output ptg_cmd_t  cmd_o
);

  localparam logic [2:0] StIdle = 3'd0;
  localparam logic [2:0] StSlot = 3'd1;
  localparam logic [2:0] StDiv  = 3'd2;
  localparam logic [2:0] StUpd  = 3'd3;
  localparam logic [2:0] StSum  = 3'd4;

  logic [2:0] state_q, state_d;
  logic [2:0] slot_q, slot_d;
  logic [4:0] cnt_q, cnt_d;
  logic       ov_q, ov_d;

  // Accept while idle and the output register is free or being drained.
  assign in_ready_o  = (state_q == StIdle) && (!ov_q || out_ready_i);
  assign out_valid_o = ov_q;

  always_comb begin
    state_d = state_q;
    slot_d  = slot_q;
    cnt_d   = cnt_q;
    ov_d    = ov_q;
    cmd_o   = '0;
    cmd_o.slot = slot_q;
    if (ov_q && out_ready_i) begin
      ov_d = 1'b0;
    end
    unique case (state_q)
      StIdle: begin
        if (in_valid_i && in_ready_o) begin
          cmd_o.load = 1'b1;
          slot_d  = '0;
          state_d = StSlot;
        end
      end
      StSlot: begin
        if (stat_i.restart) begin
          ov_d    = 1'b1;
          state_d = StIdle;
        end else if (stat_i.skip) begin
          slot_d = slot_q + 3'd1;
          if (slot_q == 3'(SchedCount - 1)) begin
            state_d = StSum;
          end
        end else begin
          cmd_o.div_start = 1'b1;
          cnt_d   = 5'(QuotWidth - 1);
          state_d = StDiv;
        end
      end
      StDiv: begin
        cmd_o.div_step = 1'b1;
        cnt_d = cnt_q - 5'd1;
        if (cnt_q == '0) begin
          state_d = StUpd;
        end
      end
      StUpd: begin
        cmd_o.sched = 1'b1;
        slot_d  = slot_q + 3'd1;
        state_d = (slot_q == 3'(SchedCount - 1)) ? StSum : StSlot;
      end
      StSum: begin
        cmd_o.sums = 1'b1;
        ov_d    = 1'b1;
        state_d = StIdle;
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      slot_q  <= '0;
      cnt_q   <= '0;
      ov_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      slot_q  <= slot_d;
      cnt_q   <= cnt_d;
      ov_q    <= ov_d;
    end
  end

  a_no_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != StIdle) |-> !in_ready_o) else $error("accept while busy");
  a_result_after_sum: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StSum) |=> ov_q) else $error("result lost");
  a_div_then_upd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StDiv && cnt_q == '0) |=> (state_q == StUpd))
    else $error("division overrun");

endmodule

>>> design/ptg_datapath.sv
module ptg_datapath
  import ptg_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  ptg_cmd_t    cmd_i,
  output ptg_stat_t   stat_o,
  input  logic [31:0] now_ms_i,
  input  logic [15:0] tempo_interval_ms_i,
  input  logic        base_edge_i,
  input  logic        swap_sets_i,
  input  logic        restart_i,
  input  logic [31:0] xa_i,
  input  logic [31:0] ya_i,
  input  logic [31:0] xb_i,
  input  logic [31:0] yb_i,
  input  logic [15:0] pulse_i,
  output logic [5:0]  gates_group_a_o,
  output logic [5:0]  gates_group_b_o
);

  logic [GateCount-1:0]  level_q;
  logic [31:0]           off_q [GateCount];
  logic [31:0]           next_q [SchedCount];
  logic [31:0]           now_q;
  logic [15:0]           tempo_q;
  logic                  swap_q, restart_q;
  logic [1:0]            fired_q;
  logic [5:0]            ga_q, gb_q;

  logic [QuotWidth-1:0]  rem_q, quo_q, num_q;
  logic [7:0]            div_q;

  logic [31:0] fire_off;
  logic [7:0]  x_sel, y_sel;
  logic        grp;
  logic [1:0]  idx;
  logic [3:0]  gidx;
  logic [31:0] xs, ys;
  logic [QuotWidth:0] trial;
  logic [31:0] step, nxt, base;
  logic        due;

  assign fire_off = now_q + {16'd0, pulse_i};
  assign grp  = cmd_i.slot[2];
  assign idx  = cmd_i.slot[1:0];
  assign gidx = grp ? 4'(GroupGates + 1) + {2'd0, idx} : 4'd1 + {2'd0, idx};

  always_comb begin
    if (grp ^ swap_q) begin
      xs = xb_i; ys = yb_i;
    end else begin
      xs = xa_i; ys = ya_i;
    end
    x_sel = xs[8*idx +: 8];
    y_sel = ys[8*idx +: 8];
  end

  assign stat_o.restart = restart_q;
  assign stat_o.skip    = (x_sel == '0);

  // Restoring division step: shift one numerator bit into the remainder.
  assign trial = {rem_q, num_q[QuotWidth-1]} - {{(QuotWidth-7){1'b0}}, div_q};

  assign step = (quo_q == '0) ? 32'd1 : {{(32-QuotWidth){1'b0}}, quo_q};
  assign nxt  = next_q[cmd_i.slot];
  assign due  = (nxt == '0) || (now_q >= nxt);
  assign base = (nxt == '0) ? now_q : nxt;

  always_ff @(posedge clk_i) begin
    if (cmd_i.div_start) begin
      num_q <= QuotWidth'(y_sel) * QuotWidth'(tempo_q);
      div_q <= x_sel;
      rem_q <= '0;
      quo_q <= '0;
    end else if (cmd_i.div_step) begin
      num_q <= {num_q[QuotWidth-2:0], 1'b0};
      if (!trial[QuotWidth]) begin
        rem_q <= trial[QuotWidth-1:0];
        quo_q <= {quo_q[QuotWidth-2:0], 1'b1};
      end else begin
        rem_q <= {rem_q[QuotWidth-2:0], num_q[QuotWidth-1]};
        quo_q <= {quo_q[QuotWidth-2:0], 1'b0};
      end
    end
    if (cmd_i.load) begin
      now_q     <= now_ms_i;
      tempo_q   <= tempo_interval_ms_i;
      swap_q    <= swap_sets_i;
      restart_q <= restart_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      level_q <= '0;
      fired_q <= '0;
      ga_q    <= '0;
      gb_q    <= '0;
      for (int i = 0; i < GateCount; i++) off_q[i] <= '0;
      for (int i = 0; i < SchedCount; i++) next_q[i] <= '0;
    end else begin
      if (cmd_i.load) begin
        fired_q <= '0;
        if (restart_i) begin
          level_q <= '0;
          for (int i = 0; i < GateCount; i++) off_q[i] <= '0;
          for (int i = 0; i < SchedCount; i++) next_q[i] <= '0;
          ga_q <= '0;
          gb_q <= '0;
        end else begin
          // Expire, then fire the base gates on an edge.
          for (int i = 0; i < GateCount; i++) begin
            if (off_q[i] != '0 && now_ms_i >= off_q[i]) begin
              level_q[i] <= 1'b0;
              off_q[i]   <= '0;
            end
          end
          if (base_edge_i) begin
            for (int g = 0; g < 2; g++) begin
              if (off_q[g*GroupGates] == '0 ||
                  now_ms_i >= off_q[g*GroupGates]) begin
                level_q[g*GroupGates] <= 1'b1;
                off_q[g*GroupGates]   <= now_ms_i + {16'd0, pulse_i};
              end
            end
          end
        end
      end
      if (cmd_i.sched && due) begin
        next_q[cmd_i.slot] <= base + step;
        if (off_q[gidx] == '0) begin
          level_q[gidx] <= 1'b1;
          off_q[gidx]   <= fire_off;
          fired_q[grp]  <= 1'b1;
        end
      end
      if (cmd_i.sums) begin
        for (int g = 0; g < 2; g++) begin
          if (fired_q[g] && off_q[g*GroupGates+SumGate] == '0) begin
            level_q[g*GroupGates+SumGate] <= 1'b1;
            off_q[g*GroupGates+SumGate]   <= fire_off;
          end
        end
        ga_q <= level_q[5:0] |
                ((fired_q[0] && off_q[SumGate] == '0) ? 6'h20 : 6'h00);
        gb_q <= level_q[11:6] |
                ((fired_q[1] && off_q[GroupGates+SumGate] == '0) ? 6'h20 : 6'h00);
      end
    end
  end

  assign gates_group_a_o = ga_q;
  assign gates_group_b_o = gb_q;

endmodule

>>> design/polyrhythm_trigger_generator.sv
// Channel | direction | handshake             | payload
// in      | to block  | in_valid_i/in_ready_o  | now_ms_i, tempo_interval_ms_i, flags
// out     | from block| out_valid_o/out_ready_i| gates_group_a_o, gates_group_b_o
// cfg     | to block  | APB psel/penable       | five registers at 4*i
// A request visits the eight ratio slots in turn; each slot with nonzero X runs
// one 24-step restoring divider shared by all slots before its schedule update.
// A restart request returns with all gates low and runs no slot.
// rst_ni clears gates and schedules at once; registers return to their defaults.
// The result waits in an output register; the next request is taken as it drains.
module polyrhythm_trigger_generator
  import ptg_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [31:0] now_ms_i,
  input  logic [15:0] tempo_interval_ms_i,
  input  logic        base_edge_i,
  input  logic        swap_sets_i,
  input  logic        restart_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [5:0]  gates_group_a_o,
  output logic [5:0]  gates_group_b_o,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  logic [31:0] xa_q, ya_q, xb_q, yb_q;
  logic [15:0] pulse_q;
  logic [2:0]  reg_idx;
  ptg_cmd_t    cmd;
  ptg_stat_t   stat;

  assign pready  = 1'b1;
  assign reg_idx = paddr[4:2];

  // Hold registers; write on the access phase.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      xa_q    <= ResetXA;
      ya_q    <= ResetYA;
      xb_q    <= ResetXB;
      yb_q    <= ResetYB;
      pulse_q <= ResetPulse;
    end else if (psel && penable && pwrite) begin
      unique case (reg_idx)
        RegXA:    xa_q    <= pwdata;
        RegYA:    ya_q    <= pwdata;
        RegXB:    xb_q    <= pwdata;
        RegYB:    yb_q    <= pwdata;
        RegPulse: pulse_q <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      RegXA:    prdata = xa_q;
      RegYA:    prdata = ya_q;
      RegXB:    prdata = xb_q;
      RegYB:    prdata = yb_q;
      RegPulse: prdata = {16'd0, pulse_q};
      default:  prdata = '0;
    endcase
  end

  ptg_ctrl u_ctrl (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_o, .out_valid_o, .out_ready_i,
    .stat_i(stat), .cmd_o(cmd)
  );

  ptg_datapath u_dp (
    .clk_i, .rst_ni, .cmd_i(cmd), .stat_o(stat),
    .now_ms_i, .tempo_interval_ms_i, .base_edge_i, .swap_sets_i, .restart_i,
    .xa_i(xa_q), .ya_i(ya_q), .xb_i(xb_q), .yb_i(yb_q), .pulse_i(pulse_q),
    .gates_group_a_o, .gates_group_b_o
  );

endmodule

>>> tb/sv/ptg_checker.sv
`timescale 1ns / 1ps
module ptg_checker
  import ptg_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  input  logic        in_ready_i,
  input  logic [31:0] now_ms_i,
  input  logic [15:0] tempo_interval_ms_i,
  input  logic        base_edge_i,
  input  logic        swap_sets_i,
  input  logic        restart_i,
  input  logic        out_valid_i,
  input  logic        out_ready_i,
  input  logic [5:0]  gates_group_a_i,
  input  logic [5:0]  gates_group_b_i,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output int          fail_count_o,
  output int          pending_o
);

  logic [31:0] xa, ya, xb, yb;
  logic [15:0] pulse;
  logic [11:0] level;
  logic [31:0] off_t [12];
  logic [31:0] next_t [8];
  logic [11:0] gate_queue [$];

  function automatic logic [31:0] slot_step(logic [7:0] x, logic [7:0] y, logic [15:0] tempo);
    logic [31:0] q;
    q = (32'(y) * 32'(tempo)) / 32'(x);
    return (q == 0) ? 32'd1 : q;
  endfunction

  task automatic fire(int g, logic [31:0] now);
    level[g] = 1'b1;
    off_t[g] = now + 32'(pulse);
  endtask

  task automatic run_group(int grp, logic [31:0] xs, logic [31:0] ys, logic [31:0] now,
                           logic [15:0] tempo, output logic any);
    logic [7:0] x, y;
    logic [31:0] st, base;
    int g, s;
    any = 1'b0;
    for (int i = 0; i < RatioUsed; i++) begin
      x = xs[8*i +: 8];
      y = ys[8*i +: 8];
      g = grp * GroupGates + 1 + i;
      s = grp * 4 + i;
      if (x != 0) begin
        st = slot_step(x, y, tempo);
        if (next_t[s] == 0 || now >= next_t[s]) begin
          base = (next_t[s] == 0) ? now : next_t[s];
          if (off_t[g] == 0) begin
            fire(g, now);
            any = 1'b1;
          end
          next_t[s] = base + st;
        end
      end
    end
  endtask

  task automatic predict_gates(logic [31:0] now, logic [15:0] tempo, logic edg, logic swp,
                               logic rst);
    logic fa, fb;
    if (rst) begin
      level = '0;
      foreach (off_t[g]) off_t[g] = '0;
      foreach (next_t[s]) next_t[s] = '0;
    end else begin
      for (int g = 0; g < GateCount; g++)
        if (off_t[g] != 0 && now >= off_t[g]) begin
          level[g] = 1'b0;
          off_t[g] = '0;
        end
      if (edg) begin
        if (off_t[0] == 0) fire(0, now);
        if (off_t[GroupGates] == 0) fire(GroupGates, now);
      end
      if (!swp) begin
        run_group(0, xa, ya, now, tempo, fa);
        run_group(1, xb, yb, now, tempo, fb);
      end else begin
        run_group(0, xb, yb, now, tempo, fa);
        run_group(1, xa, ya, now, tempo, fb);
      end
      if (fa && off_t[SumGate] == 0) fire(SumGate, now);
      if (fb && off_t[GroupGates + SumGate] == 0) fire(GroupGates + SumGate, now);
    end
    gate_queue.push_back(level);
  endtask

  assign pending_o = gate_queue.size();

  always_ff @(posedge clk_i or negedge rst_ni) begin
    logic [11:0] exp_l;
    if (!rst_ni) begin
      xa <= ResetXA; ya <= ResetYA; xb <= ResetXB; yb <= ResetYB; pulse <= ResetPulse;
      level = '0;
      foreach (off_t[g]) off_t[g] = '0;
      foreach (next_t[s]) next_t[s] = '0;
      gate_queue.delete();
      fail_count_o <= 0;
    end else begin
      if (psel && penable && pwrite) begin
        case (paddr[4:2])
          RegXA:    xa <= pwdata;
          RegYA:    ya <= pwdata;
          RegXB:    xb <= pwdata;
          RegYB:    yb <= pwdata;
          RegPulse: pulse <= pwdata[15:0];
          default: ;
        endcase
      end
      if (out_valid_i && out_ready_i) begin
        if (gate_queue.size() == 0) begin
          if (fail_count_o < 10) $display("unexpected result a=%h b=%h",
                                          gates_group_a_i, gates_group_b_i);
          fail_count_o <= fail_count_o + 1;
        end else begin
          exp_l = gate_queue.pop_front();
          if (exp_l[5:0] !== gates_group_a_i || exp_l[11:6] !== gates_group_b_i) begin
            if (fail_count_o < 10)
              $display("gate mismatch: exp a=%h b=%h got a=%h b=%h", exp_l[5:0],
                       exp_l[11:6], gates_group_a_i, gates_group_b_i);
            fail_count_o <= fail_count_o + 1;
          end
        end
      end
      if (in_valid_i && in_ready_i)
        predict_gates(now_ms_i, tempo_interval_ms_i, base_edge_i, swap_sets_i, restart_i);
    end
  end

endmodule

>>> tb/sv/tb_polyrhythm_trigger_generator.sv
`timescale 1ns / 1ps
module tb_polyrhythm_trigger_generator;
  import ptg_pkg::*;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_ready_o;
  logic [31:0] now_ms_i = '0;
  logic [15:0] tempo_interval_ms_i = '0;
  logic        base_edge_i = 1'b0;
  logic        swap_sets_i = 1'b0;
  logic        restart_i = 1'b0;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  logic [5:0]  gates_group_a_o;
  logic [5:0]  gates_group_b_o;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [4:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  int fail_count, pending, sent_count, idle_cycles, restart_count;
  bit calm;          // stretch with no idling on either side
  logic [31:0] clock_ms;

  polyrhythm_trigger_generator DUT (.*);

  ptg_checker u_checker (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_i(in_ready_o), .now_ms_i, .tempo_interval_ms_i,
    .base_edge_i, .swap_sets_i, .restart_i, .out_valid_i(out_valid_o), .out_ready_i,
    .gates_group_a_i(gates_group_a_o), .gates_group_b_i(gates_group_b_o),
    .psel, .penable, .pwrite, .paddr, .pwdata,
    .fail_count_o(fail_count), .pending_o(pending)
  );

  initial begin
    forever #10 clk_i = ~clk_i;
  end

  // Watchdog: count cycles with no handshake on either channel.
  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles > 20000) begin
      $display("Mismatches found");
      $finish;
    end
  end

  // Receiver: stall at random with a chance of 13 percent, except during the calm stretch.
  always @(posedge clk_i) begin
    out_ready_i <= calm || ($urandom_range(99) >= 13);
  end

  task automatic write_reg(logic [2:0] idx, logic [31:0] val);
    psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1; paddr <= {idx, 2'b00}; pwdata <= val;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    @(posedge clk_i);
  endtask

  // Drop valid, drain all results, then hold off past the longest request latency.
  task automatic settle();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (250) @(posedge clk_i);
  endtask

  // Valid stays high after acceptance until the next idle cycle or the next request,
  // so that it is assigned only once per time step.
  task automatic send_tick(logic [31:0] now, logic [15:0] tempo, logic edg, logic swp,
                           logic rst);
    while (!calm && $urandom_range(99) < 13) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    now_ms_i <= now; tempo_interval_ms_i <= tempo;
    base_edge_i <= edg; swap_sets_i <= swp; restart_i <= rst;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    sent_count++;
    if (rst) restart_count++;
  endtask

  // Advance the millisecond clock by a small step; mostly a well-formed run of ticks.
  task automatic random_ticks(int n, logic [15:0] tmax);
    for (int i = 0; i < n; i++) begin
      clock_ms = clock_ms + (($urandom_range(9) == 0) ? $urandom : $urandom_range(4));
      send_tick(clock_ms, $urandom_range(tmax), $urandom_range(3) == 0,
                $urandom_range(7) == 0, $urandom_range(49) == 0);
    end
  endtask

  initial begin
    calm = 1'b0;
    restart_count = 0;
    sent_count = 0;
    idle_cycles = 0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: defaults, zero time, extremes of tempo and time, wrap, restart.
    send_tick(32'd0, 16'd0, 1'b1, 1'b0, 1'b0);
    send_tick(32'd1, 16'hFFFF, 1'b0, 1'b0, 1'b0);
    send_tick(32'd5, 16'd100, 1'b1, 1'b1, 1'b0);
    send_tick(32'd12, 16'd100, 1'b0, 1'b0, 1'b0);
    send_tick(32'd20, 16'd100, 1'b1, 1'b0, 1'b1);
    send_tick(32'hFFFF_FFF8, 16'd3, 1'b1, 1'b0, 1'b0);
    send_tick(32'hFFFF_FFFE, 16'd3, 1'b0, 1'b0, 1'b0);
    send_tick(32'd2, 16'd3, 1'b1, 1'b1, 1'b0);
    send_tick(32'hFFFF_FFFF, 16'hFFFF, 1'b1, 1'b1, 1'b0);
    send_tick(32'd0, 16'd0, 1'b0, 1'b0, 1'b1);
    settle();

    // Extremes: all-ones ratios, zero pulse width (off time wraps case too).
    write_reg(RegXA, 32'hFFFF_FFFF); write_reg(RegYA, 32'hFFFF_FFFF);
    write_reg(RegXB, 32'h0000_0001); write_reg(RegYB, 32'h0000_00FF);
    write_reg(RegPulse, 32'd0);
    send_tick(32'd10, 16'hFFFF, 1'b1, 1'b0, 1'b0);
    send_tick(32'd11, 16'hFFFF, 1'b1, 1'b1, 1'b0);
    send_tick(32'd0, 16'd1, 1'b1, 1'b0, 1'b0);
    send_tick(32'd1, 16'd1, 1'b1, 1'b0, 1'b0);
    settle();
    write_reg(RegXA, 32'd0); write_reg(RegXB, 32'd0); write_reg(RegPulse, 32'hFFFF);
    send_tick(32'd100, 16'd50, 1'b1, 1'b0, 1'b0);
    send_tick(32'h0001_0000, 16'd50, 1'b1, 1'b0, 1'b0);
    settle();
    // Off time wraps to zero: pulse 16 fired at 2^32-16.
    write_reg(RegXA, 32'h0102_0304); write_reg(RegPulse, 32'd16);
    send_tick(32'hFFFF_FFF0, 16'd8, 1'b1, 1'b0, 1'b0);
    send_tick(32'hFFFF_FFF4, 16'd8, 1'b1, 1'b0, 1'b0);
    send_tick(32'd3, 16'd8, 1'b1, 1'b0, 1'b1);
    settle();

    // Random phases with fresh register settings; pulse widths mostly short.
    for (int ph = 0; ph < 6; ph++) begin
      write_reg(RegXA, $urandom); write_reg(RegYA, $urandom);
      write_reg(RegXB, ($urandom_range(3) == 0) ? $urandom : $urandom & 32'h0707_0707);
      write_reg(RegYB, $urandom & 32'h0F0F_0F0F);
      write_reg(RegPulse, (ph == 5) ? 32'hFFFF : $urandom_range(ph == 0 ? 0 : 1, 12));
      clock_ms = $urandom_range(1000);
      calm = (ph == 2);
      random_ticks(80, (ph == 3) ? 16'hFFFF : 16'd40);
      settle();
    end
    calm = 1'b0;

    $display("Sent %0d ticks (%0d restarts) across default, extreme and random settings.",
             sent_count, restart_count);
    if (fail_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
